// ----- rtl/core/srsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants, codes and controller/datapath interface types for the
// selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_BITS   = 3;
    localparam int SEQ_SPACE  = 1 << SEQ_BITS;
    localparam int MAX_WINDOW = 8;
    localparam int WIN_CAP    = (MAX_WINDOW < SEQ_SPACE) ? MAX_WINDOW : SEQ_SPACE;
    localparam int CNT_W      = $clog2(WIN_CAP + 1);
    localparam int WSZ_W      = 4;
    localparam int ACT_W      = 2;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [ACT_W-1:0] ACT_SEND   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXPIRE = 2'd2;

    typedef logic [SEQ_BITS-1:0] seq_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic slide_step;
        logic slide_end;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ack_hit;
        logic slide_more;
        logic out_free;
    } ctrl_status_t;

endpackage

// ----- rtl/core/srsw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: takes an event word, runs it, walks the window base past acked
// entries one per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module srsw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  srsw_pkg::ctrl_status_t status,
    output srsw_pkg::ctrl_cmd_t   cmd
);
    import srsw_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SLIDE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.ack_hit ? ST_SLIDE : ST_FINISH;
            end
            ST_SLIDE: begin
                if (status.slide_more) begin
                    cmd.slide_step = 1'b1;
                end else begin
                    cmd.slide_end = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/srsw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_datapath
// Window state, per-sequence acked marks, event evaluation, result build-up
// and the output register.
// ----------------------------------------------------------------------------
module srsw_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [srsw_pkg::WSZ_W-1:0]    cfg_data,
    input  logic [srsw_pkg::ACT_W-1:0]    s_tuser,
    input  logic [srsw_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srsw_pkg::M_DATA_W-1:0] m_tdata,
    input  srsw_pkg::ctrl_cmd_t           cmd,
    output srsw_pkg::ctrl_status_t        status
);
    import srsw_pkg::*;

    logic [WSZ_W-1:0]     wsize_reg;
    seq_t                 base_reg, base_next;
    seq_t                 nseq_reg, nseq_next;
    cnt_t                 count_reg, count_next;
    logic [SEQ_SPACE-1:0] marks_reg, marks_next;
    logic                 full_reg, full_next;

    logic [ACT_W-1:0] act_reg;
    seq_t             ack_seq_reg;
    logic             ack_ok_reg;
    seq_t             exp_seq_reg;

    logic accepted_reg, accepted_next;
    logic txv_reg, txv_next;
    seq_t txseq_reg, txseq_next;
    logic tstart_reg, tstart_next;
    logic tstop_reg, tstop_next;
    seq_t tseq_reg, tseq_next;
    cnt_t released_reg, released_next;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [WSZ_W-1:0] eff_win;
    seq_t             ack_off;
    seq_t             exp_off;
    logic             send_ok;
    logic             ack_hit;
    logic             exp_hit;
    cnt_t             count_inc;

    always_comb begin
        if (wsize_reg == '0) begin
            eff_win = WSZ_W'(1);
        end else if (wsize_reg > WSZ_W'(WIN_CAP)) begin
            eff_win = WSZ_W'(WIN_CAP);
        end else begin
            eff_win = wsize_reg;
        end
    end

    assign ack_off   = ack_seq_reg - base_reg;
    assign exp_off   = exp_seq_reg - base_reg;
    assign count_inc = count_reg + CNT_W'(1);
    assign send_ok   = (act_reg == ACT_SEND) && !full_reg && (count_reg < CNT_W'(WIN_CAP));
    assign ack_hit   = (act_reg == ACT_ACK) && (count_reg != '0) && ack_ok_reg
                       && (CNT_W'(ack_off) < count_reg);
    assign exp_hit   = (act_reg == ACT_EXPIRE) && (count_reg != '0)
                       && (CNT_W'(exp_off) < count_reg);

    assign status.ack_hit    = ack_hit;
    assign status.slide_more = (count_reg != '0) && marks_reg[base_reg];
    assign status.out_free   = !m_valid_reg || m_tready;

    always_comb begin
        base_next     = base_reg;
        nseq_next     = nseq_reg;
        count_next    = count_reg;
        marks_next    = marks_reg;
        full_next     = full_reg;
        accepted_next = accepted_reg;
        txv_next      = txv_reg;
        txseq_next    = txseq_reg;
        tstart_next   = tstart_reg;
        tstop_next    = tstop_reg;
        tseq_next     = tseq_reg;
        released_next = released_reg;

        if (cmd.exec) begin
            accepted_next = 1'b0;
            txv_next      = 1'b0;
            txseq_next    = '0;
            tstart_next   = 1'b0;
            tstop_next    = 1'b0;
            tseq_next     = '0;
            released_next = '0;
            case (act_reg)
                ACT_SEND: begin
                    if (send_ok) begin
                        marks_next[nseq_reg] = 1'b0;
                        accepted_next        = 1'b1;
                        txv_next             = 1'b1;
                        txseq_next           = nseq_reg;
                        tstart_next          = 1'b1;
                        tseq_next            = nseq_reg;
                        count_next           = count_inc;
                        if (WSZ_W'(count_inc) >= eff_win) begin
                            full_next = 1'b1;
                        end
                        nseq_next = nseq_reg + SEQ_BITS'(1);
                    end
                end
                ACT_ACK: begin
                    if (ack_hit) begin
                        marks_next[ack_seq_reg] = 1'b1;
                        tstop_next              = 1'b1;
                        tseq_next               = ack_seq_reg;
                    end
                end
                ACT_EXPIRE: begin
                    if (exp_hit) begin
                        txv_next    = 1'b1;
                        txseq_next  = exp_seq_reg;
                        tstart_next = 1'b1;
                        tseq_next   = exp_seq_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.slide_step) begin
            marks_next[base_reg] = 1'b0;
            base_next            = base_reg + SEQ_BITS'(1);
            count_next           = count_reg - CNT_W'(1);
            released_next        = released_reg + CNT_W'(1);
        end

        if (cmd.slide_end && (WSZ_W'(count_reg) < eff_win)) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg   <= WSZ_W'(4);
            base_reg    <= '0;
            nseq_reg    <= '0;
            count_reg   <= '0;
            marks_reg   <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                wsize_reg <= cfg_data;
            end
            base_reg  <= base_next;
            nseq_reg  <= nseq_next;
            count_reg <= count_next;
            marks_reg <= marks_next;
            full_reg  <= full_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        accepted_reg <= accepted_next;
        txv_reg      <= txv_next;
        txseq_reg    <= txseq_next;
        tstart_reg   <= tstart_next;
        tstop_reg    <= tstop_next;
        tseq_reg     <= tseq_next;
        released_reg <= released_next;
        if (cmd.load_in) begin
            act_reg     <= s_tuser;
            ack_seq_reg <= s_tdata[2:0];
            ack_ok_reg  <= s_tdata[3];
            exp_seq_reg <= s_tdata[6:4];
        end
        if (cmd.load_out) begin
            m_data_reg <= {5'd0, released_reg, count_reg, full_reg, tseq_reg, tstop_reg,
                           tstart_reg, txseq_reg, txv_reg, accepted_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/selective_repeat_sender_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat ARQ window. Each input word is one event
// (send request, acknowledgement, or timer expiry); each event yields exactly
// one result word telling the host which sequence number to transmit and
// which timer to start or stop, plus the window occupancy after the event.
// Sends, expiries and ignored events pass through the execute and finish
// states; a valid acknowledgement also passes through the slide state, where
// the base advances past acked entries one entry per cycle. A finished
// result sits in the output register while the next event is taken.
// window_size must be written through cfg_* only while the block is idle;
// the block does not enforce it; values outside 1..8 saturate into that range.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: window_size
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [srsw_pkg::WSZ_W-1:0]    cfg_data,
    // events
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srsw_pkg::S_DATA_W-1:0] s_tdata,  // ack_seq, ack_check_ok, expired_seq
    input  logic [srsw_pkg::ACT_W-1:0]    s_tuser,  // action
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // send_accepted, tx_valid, tx_seq, timer_start, timer_stop, timer_seq,
    // window_full, outstanding, released
    output logic [srsw_pkg::M_DATA_W-1:0] m_tdata
);
    import srsw_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    srsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srsw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
